>>> sv/bmscan_pkg.sv
// Package for the bitmap set/scan unit: sizes, command codes, FSM states, helpers.
`default_nettype none
package bmscan_pkg;

    localparam int CAPACITY   = 1024;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = 32;
    localparam int INDEX_W    = 10;
    localparam int ADDR_W     = $clog2(WORD_COUNT);
    localparam int POS_W      = $clog2(WORD_BITS);
    localparam int SCAN_W     = ADDR_W + 1;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [POS_W-1:0]     pos_t;

    localparam word_t TOP_BIT = word_t'(32'h8000_0000);

    typedef enum logic [2:0] {
        CMD_CLEAR_ALL = 3'd0,
        CMD_CLEAR_BIT = 3'd1,
        CMD_SET_BIT   = 3'd2,
        CMD_TEST_BIT  = 3'd3,
        CMD_RESTART   = 3'd4,
        CMD_NEXT_SET  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_SCAN
    } state_t;

    // Count leading zeros from the MSB; an all-zero word gives 0 (never used)
    function automatic pos_t lead_zeros(input word_t w);
        pos_t n;
        logic hit;
        n   = '0;
        hit = 1'b0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (w[WORD_BITS-1-i] && !hit)
            begin
                n   = pos_t'(i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

>>> sv/bmscan_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bmscan_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/bitmap_set_with_next_set_scan_unit.sv
// Top level of the bitmap set/scan unit: command FSM around the word RAM.
//
// Usage: present command and bit_index with start; a beat is taken at the
// rising edge where start is high and busy is low. Each command yields one
// result beat on bit_value, found and found_index, marked by done for a
// single cycle; the receiver cannot stall, so results are never held.
// Steps per command:
//   clear all, restart scan, unused codes, next-set with bits left in the
//     current snapshot word or with the scan past the last word: done is
//     registered straight from idle, with no RAM access.
//   set, clear, test bit: one RAM read, then modify/write back.
//   next-set needing new words: the walk reads one RAM word per cycle until
//     a set bit turns up or the last word is read.
// A new command may be accepted in the cycle its predecessor's done is high.
// Reset clears the per-word valid flags, so every word reads as zero with
// no clearing pass; clear all does the same. Reset also puts the scan
// before the first word.
`default_nettype none
module bitmap_set_with_next_set_scan_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic [2:0]                        command,
    input  wire logic [bmscan_pkg::INDEX_W-1:0]    bit_index,
    output      logic                              done,
    output      logic                              bit_value,
    output      logic                              found,
    output      logic [bmscan_pkg::INDEX_W-1:0]    found_index
);

    bmscan_pkg::state_t                  state_reg, state_next;
    bmscan_pkg::cmd_t                    cmd_reg, cmd_next;
    logic [bmscan_pkg::ADDR_W-1:0]       word_addr_reg, word_addr_next;
    bmscan_pkg::pos_t                    bit_pos_reg, bit_pos_next;
    logic [bmscan_pkg::SCAN_W-1:0]       scan_word_reg, scan_word_next;
    logic                                scan_started_reg, scan_started_next;
    bmscan_pkg::word_t                   remain_reg, remain_next;
    logic [bmscan_pkg::WORD_COUNT-1:0]   valid_reg, valid_next;
    logic                                done_reg, done_next;
    logic                                bit_value_reg, bit_value_next;
    logic                                found_reg, found_next;
    logic [bmscan_pkg::INDEX_W-1:0]      found_index_reg, found_index_next;

    logic                                ram_we, ram_re;
    logic [bmscan_pkg::ADDR_W-1:0]       ram_raddr;
    bmscan_pkg::word_t                   ram_wdata, ram_rdata;

    bmscan_pkg::word_t                   rd_word, bit_mask;
    bmscan_pkg::pos_t                    lz_remain, lz_rd;
    logic [bmscan_pkg::SCAN_W-1:0]       scan_first;
    logic                                accept;

    bmscan_ram #(
        .WIDTH (bmscan_pkg::WORD_BITS),
        .DEPTH (bmscan_pkg::WORD_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (word_addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy        = (state_reg != bmscan_pkg::ST_IDLE);
    assign accept      = start && !busy;
    assign done        = done_reg;
    assign bit_value   = bit_value_reg;
    assign found       = found_reg;
    assign found_index = found_index_reg;

    // Mask never-written words to zero
    assign rd_word   = valid_reg[word_addr_reg] ? ram_rdata : '0;
    assign bit_mask  = bmscan_pkg::TOP_BIT >> bit_pos_reg;
    assign lz_remain = bmscan_pkg::lead_zeros(remain_reg);
    assign lz_rd     = bmscan_pkg::lead_zeros(rd_word);

    // Pick the word where a fresh scan step begins
    always_comb
    begin
        if (!scan_started_reg)
        begin
            scan_first = '0;
        end
        else if (scan_word_reg < bmscan_pkg::SCAN_W'(bmscan_pkg::WORD_COUNT))
        begin
            scan_first = scan_word_reg + bmscan_pkg::SCAN_W'(1);
        end
        else
        begin
            scan_first = bmscan_pkg::SCAN_W'(bmscan_pkg::WORD_COUNT);
        end
    end

    // Next state, RAM access and result beat
    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        word_addr_next    = word_addr_reg;
        bit_pos_next      = bit_pos_reg;
        scan_word_next    = scan_word_reg;
        scan_started_next = scan_started_reg;
        remain_next       = remain_reg;
        valid_next        = valid_reg;
        done_next         = 1'b0;
        bit_value_next    = 1'b0;
        found_next        = 1'b0;
        found_index_next  = '0;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        ram_raddr         = '0;
        ram_wdata         = rd_word;

        case (state_reg)
            bmscan_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (bmscan_pkg::cmd_t'(command))
                        bmscan_pkg::CMD_CLEAR_ALL:
                        begin
                            valid_next = '0;
                            done_next  = 1'b1;
                        end
                        bmscan_pkg::CMD_CLEAR_BIT, bmscan_pkg::CMD_SET_BIT,
                        bmscan_pkg::CMD_TEST_BIT:
                        begin
                            // Every 10-bit index is below capacity
                            cmd_next       = bmscan_pkg::cmd_t'(command);
                            word_addr_next = bit_index[bmscan_pkg::INDEX_W-1:bmscan_pkg::POS_W];
                            bit_pos_next   = bit_index[bmscan_pkg::POS_W-1:0];
                            ram_re         = 1'b1;
                            ram_raddr      = bit_index[bmscan_pkg::INDEX_W-1:bmscan_pkg::POS_W];
                            state_next     = bmscan_pkg::ST_RMW;
                        end
                        bmscan_pkg::CMD_RESTART:
                        begin
                            scan_word_next    = '0;
                            scan_started_next = 1'b0;
                            remain_next       = '0;
                            done_next         = 1'b1;
                        end
                        bmscan_pkg::CMD_NEXT_SET:
                        begin
                            if (remain_reg != '0)
                            begin
                                // Pop the next bit of the snapshot word
                                remain_next      = remain_reg ^ (bmscan_pkg::TOP_BIT >> lz_remain);
                                found_next       = 1'b1;
                                found_index_next = {scan_word_reg[bmscan_pkg::ADDR_W-1:0],
                                                    lz_remain};
                                done_next        = 1'b1;
                            end
                            else
                            begin
                                scan_started_next = 1'b1;
                                scan_word_next    = scan_first;
                                if (scan_first == bmscan_pkg::SCAN_W'(bmscan_pkg::WORD_COUNT))
                                begin
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    ram_re         = 1'b1;
                                    ram_raddr      = scan_first[bmscan_pkg::ADDR_W-1:0];
                                    word_addr_next = scan_first[bmscan_pkg::ADDR_W-1:0];
                                    state_next     = bmscan_pkg::ST_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            bmscan_pkg::ST_RMW:
            begin
                // Modify the fetched word and write it back
                case (cmd_reg)
                    bmscan_pkg::CMD_SET_BIT:
                    begin
                        ram_we                    = 1'b1;
                        ram_wdata                 = rd_word | bit_mask;
                        valid_next[word_addr_reg] = 1'b1;
                    end
                    bmscan_pkg::CMD_CLEAR_BIT:
                    begin
                        ram_we                    = 1'b1;
                        ram_wdata                 = rd_word & ~bit_mask;
                        valid_next[word_addr_reg] = 1'b1;
                    end
                    default:
                    begin
                        bit_value_next = |(rd_word & bit_mask);
                    end
                endcase
                done_next  = 1'b1;
                state_next = bmscan_pkg::ST_IDLE;
            end

            bmscan_pkg::ST_SCAN:
            begin
                if (rd_word != '0)
                begin
                    // Snapshot the word and return its first set bit
                    remain_next      = rd_word ^ (bmscan_pkg::TOP_BIT >> lz_rd);
                    found_next       = 1'b1;
                    found_index_next = {word_addr_reg, lz_rd};
                    done_next        = 1'b1;
                    state_next       = bmscan_pkg::ST_IDLE;
                end
                else if (word_addr_reg == bmscan_pkg::ADDR_W'(bmscan_pkg::WORD_COUNT - 1))
                begin
                    // Park the scan past the last word
                    scan_word_next = bmscan_pkg::SCAN_W'(bmscan_pkg::WORD_COUNT);
                    done_next      = 1'b1;
                    state_next     = bmscan_pkg::ST_IDLE;
                end
                else
                begin
                    // Advance to the next word
                    ram_re         = 1'b1;
                    ram_raddr      = word_addr_reg + bmscan_pkg::ADDR_W'(1);
                    word_addr_next = word_addr_reg + bmscan_pkg::ADDR_W'(1);
                    scan_word_next = scan_word_reg + bmscan_pkg::SCAN_W'(1);
                end
            end

            default:
            begin
                state_next = bmscan_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bmscan_pkg::ST_IDLE;
            scan_word_reg    <= '0;
            scan_started_reg <= 1'b0;
            remain_reg       <= '0;
            valid_reg        <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            scan_word_reg    <= scan_word_next;
            scan_started_reg <= scan_started_next;
            remain_reg       <= remain_next;
            valid_reg        <= valid_next;
            done_reg         <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        word_addr_reg   <= word_addr_next;
        bit_pos_reg     <= bit_pos_next;
        bit_value_reg   <= bit_value_next;
        found_reg       <= found_next;
        found_index_reg <= found_index_next;
    end

`ifndef SYNTHESIS
    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(found && bit_value))
        else $error("test bit and found reported in the same beat");

    a_rmw_takes_read: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == bmscan_pkg::CMD_TEST_BIT ||
         command == bmscan_pkg::CMD_SET_BIT || command == bmscan_pkg::CMD_CLEAR_BIT))
        |=> (busy && !done))
        else $error("bit command skipped its RAM read");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_word_reg <= bmscan_pkg::SCAN_W'(bmscan_pkg::WORD_COUNT))
        else $error("scan position beyond the end");

    a_scan_started: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bmscan_pkg::ST_SCAN) |-> scan_started_reg)
        else $error("word walk without a started scan");
`endif

endmodule
`default_nettype wire
